### rtl/core/pca_pkg.sv
// Shared constants and codes of the pointwise convolution with activation block.
package pca_pkg;

  localparam int MAX_IN_CH  = 64;
  localparam int MAX_OUT_CH = 64;

  localparam int IN_IDX_W  = 6;
  localparam int OUT_IDX_W = 6;
  localparam int W_ADDR_W  = IN_IDX_W + OUT_IDX_W;
  localparam int W_DEPTH   = MAX_IN_CH * MAX_OUT_CH;

  localparam int VAL_W   = 16;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = VAL_W + ACC_W;
  localparam int CNT_W   = 7;
  localparam int OC_CNT_W = $clog2(MAX_OUT_CH + 1);

  localparam int SRC_MAX = (MAX_IN_CH < 64) ? MAX_IN_CH : 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_SLOPE  = 2'd2,
    ACT_SAMPLE = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_CH   = 3'd0,
    CFG_DST_CH   = 3'd1,
    CFG_MODE     = 3'd2,
    CFG_BIAS_EN  = 3'd3,
    CFG_SLOPE_LO = 3'd4,
    CFG_RANGE_HI = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_IDENT = 3'd0,
    MODE_RELU  = 3'd1,
    MODE_LEAKY = 3'd2,
    MODE_CLAMP = 3'd3,
    MODE_PRELU = 3'd4
  } act_mode_e;

endpackage

### rtl/core/pca_if.sv
// Valid/ready stream interfaces for the input items and the result items.
interface pca_in_if;
  import pca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IN_IDX_W-1:0]     in_index;
  logic [OUT_IDX_W-1:0]    out_index;
  logic signed [VAL_W-1:0] value;

  modport source(output valid, action, in_index, out_index, value, input ready);
  modport sink(input valid, action, in_index, out_index, value, output ready);
endinterface

interface pca_out_if;
  import pca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_W-1:0]    out_channel;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;

  modport source(output valid, out_channel, out_value, last, input ready);
  modport sink(input valid, out_channel, out_value, last, output ready);
endinterface

### rtl/core/pointwise_conv_activation.sv
// Pointwise (1x1) convolution for one pixel with bias and a selectable activation.
//
// The input channel carries load beats (weight, bias, PReLU slope) and sample beats.
// Load beats write their store in the cycle they are accepted; the block is ready
// again in the next cycle. Sample beats bring one pixel's input channels in order.
// Each sample is swept over the active output channels through one shared
// multiplier, one output channel per cycle.
// The sample that completes the pixel is followed by one result beat per output
// channel, each passing through S_RD, S_SUM, S_MUL and S_ACT on the same multiplier
// and the rounding logic. The last result carries last. The block takes no input
// beat while a sample or a pixel end is being worked on. Results leave through an
// output register; while the receiver stalls, the block holds the current beat and
// waits before producing the next one. The user must write configuration through
// the plain write port only while the block is idle; the block does not enforce
// it. Reset clears the accumulators, the channel count and the configuration to
// its defaults. Weight, bias and slope stores hold nothing useful until written.
module pointwise_conv_activation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pca_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pca_in_if.sink                           in_i,
  pca_out_if.source                        out_o
);
  import pca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_RD,
    S_SUM,
    S_MUL,
    S_ACT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [CNT_W-1:0]        src_q;
  logic [CNT_W-1:0]        dst_q;
  logic [2:0]              mode_q;
  logic                    bias_en_q;
  logic signed [VAL_W-1:0] low_q;
  logic signed [VAL_W-1:0] high_q;

  // Control.
  logic [CNT_W-1:0]     count_q;
  logic [IN_IDX_W-1:0]  ic_q;
  logic                 ic_ok_q;
  logic [OC_CNT_W-1:0]  oc_q;
  logic                 p1_vld_q;
  logic [OUT_IDX_W-1:0] p1_oc_q;
  logic                 p2_vld_q;
  logic [OUT_IDX_W-1:0] p2_oc_q;
  logic [MAX_OUT_CH-1:0] acc_vld_q;

  logic                    out_valid_q;
  logic [OUT_IDX_W-1:0]    out_channel_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_last_q;

  // Datapath.
  logic signed [VAL_W-1:0]  sample_q;
  logic signed [VAL_W-1:0]  w_rd_q;
  logic signed [VAL_W-1:0]  bias_rd_q;
  logic signed [VAL_W-1:0]  slope_rd_q;
  logic signed [ACC_W-1:0]  acc_rd_q;
  logic                     acc_vld_rd_q;
  logic signed [ACC_W-1:0]  acc_p2_q;
  logic signed [ACC_W-1:0]  v_q;
  logic signed [PROD_W-1:0] mul_q;

  // Stores.
  logic [VAL_W-1:0] w_mem     [W_DEPTH];
  logic [VAL_W-1:0] bias_mem  [MAX_OUT_CH];
  logic [VAL_W-1:0] slope_mem [MAX_OUT_CH];
  logic [ACC_W-1:0] acc_mem   [MAX_OUT_CH];

  logic                     in_accept;
  logic [CNT_W-1:0]         src_lim;
  logic [OC_CNT_W-1:0]      dst_lim;
  logic                     issue;
  logic                     pipe_empty;
  logic                     last_oc;
  logic [OUT_IDX_W-1:0]     oc_idx;
  logic signed [VAL_W-1:0]  mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  lo_ext;
  logic signed [ACC_W-1:0]  hi_ext;
  logic signed [ACC_W-1:0]  act_x;
  logic                     use_r16;
  logic signed [ACC_W:0]    rnd8_sum;
  logic signed [ACC_W-8:0]  rnd8;
  logic signed [PROD_W:0]   rnd16_sum;
  logic signed [ACC_W:0]    rnd16;
  logic signed [VAL_W-1:0]  act_val;
  logic signed [ACC_W-1:0]  bias_term;

  function automatic logic [VAL_W-1:0] sat16(input logic signed [ACC_W:0] x);
    logic [VAL_W-1:0] r;
    if (x > (ACC_W+1)'(signed'(32'sd32767))) begin
      r = 16'h7fff;
    end else if (x < (ACC_W+1)'(signed'(-32'sd32768))) begin
      r = 16'h8000;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_channel_q;
  assign out_o.out_value   = out_value_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    src_lim = src_q;
    if (src_q == '0) begin
      src_lim = CNT_W'(1);
    end else if (src_q > CNT_W'(SRC_MAX)) begin
      src_lim = CNT_W'(SRC_MAX);
    end
  end

  always_comb begin
    dst_lim = OC_CNT_W'(dst_q);
    if (dst_q == '0) begin
      dst_lim = OC_CNT_W'(1);
    end else if (dst_q > CNT_W'(MAX_OUT_CH)) begin
      dst_lim = OC_CNT_W'(MAX_OUT_CH);
    end
  end

  assign oc_idx     = oc_q[OUT_IDX_W-1:0];
  assign issue      = (state_q == S_MAC) && ic_ok_q && (oc_q < dst_lim);
  assign pipe_empty = !p1_vld_q && !p2_vld_q;
  assign last_oc    = (OC_CNT_W'(oc_q + 1'b1) == dst_lim);

  // The shared multiplier: sample times weight during the sweep, slope times sum
  // when a result is produced.
  always_comb begin
    if (state_q == S_MAC) begin
      mul_a = sample_q;
      mul_b = {{(ACC_W-VAL_W){w_rd_q[VAL_W-1]}}, w_rd_q};
    end else begin
      mul_a = (mode_q == MODE_LEAKY) ? low_q : slope_rd_q;
      mul_b = v_q;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign bias_term = bias_en_q ?
                     {{(ACC_W-VAL_W-8){bias_rd_q[VAL_W-1]}}, bias_rd_q, 8'b0} : '0;

  // Activation, rounding and saturation of the sum in v_q.
  assign lo_ext = {{(ACC_W-VAL_W-8){low_q[VAL_W-1]}}, low_q, 8'b0};
  assign hi_ext = {{(ACC_W-VAL_W-8){high_q[VAL_W-1]}}, high_q, 8'b0};

  always_comb begin
    act_x   = v_q;
    use_r16 = 1'b0;
    unique case (mode_q)
      MODE_RELU: begin
        if (v_q < 0) act_x = '0;
      end
      MODE_LEAKY, MODE_PRELU: begin
        if (v_q < 0) use_r16 = 1'b1;
      end
      MODE_CLAMP: begin
        // The upper limit is applied last, so it wins on an inverted range.
        if (v_q < lo_ext) act_x = lo_ext;
        if (act_x > hi_ext) act_x = hi_ext;
      end
      default: begin
      end
    endcase
  end

  assign rnd8_sum  = {act_x[ACC_W-1], act_x} + (ACC_W+1)'(128);
  assign rnd8      = rnd8_sum[ACC_W:8];
  assign rnd16_sum = {mul_q[PROD_W-1], mul_q} + (PROD_W+1)'(32768);
  assign rnd16     = rnd16_sum[PROD_W:16];
  assign act_val   = use_r16 ? sat16(rnd16) : sat16({{8{rnd8[ACC_W-8]}}, rnd8});

  // Stores: written on load beats and by the accumulate pipeline.
  always_ff @(posedge clk_i) begin
    if (in_accept && (in_i.action == ACT_WEIGHT)) begin
      w_mem[{in_i.in_index, in_i.out_index}] <= in_i.value;
    end
    w_rd_q <= w_mem[{ic_q, oc_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (in_i.action == ACT_BIAS)) begin
      bias_mem[in_i.out_index] <= in_i.value;
    end
    bias_rd_q <= bias_mem[oc_idx];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (in_i.action == ACT_SLOPE)) begin
      slope_mem[in_i.out_index] <= in_i.value;
    end
    slope_rd_q <= slope_mem[oc_idx];
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q) begin
      acc_mem[p2_oc_q] <= acc_p2_q + mul_q[ACC_W-1:0];
    end
    acc_rd_q <= acc_mem[oc_idx];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_vld_rd_q <= acc_vld_q[oc_idx];
    acc_p2_q     <= acc_vld_rd_q ? acc_rd_q : '0;
    mul_q        <= mul_p;
    if (in_accept) begin
      sample_q <= in_i.value;
    end
    if (state_q == S_SUM) begin
      v_q <= (acc_vld_rd_q ? acc_rd_q : '0) + bias_term;
    end
  end

  // Sequencer, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      src_q         <= CNT_W'(1);
      dst_q         <= CNT_W'(1);
      mode_q        <= MODE_IDENT;
      bias_en_q     <= 1'b1;
      low_q         <= '0;
      high_q        <= 16'sh7fff;
      count_q       <= '0;
      ic_q          <= '0;
      ic_ok_q       <= 1'b0;
      oc_q          <= '0;
      p1_vld_q      <= 1'b0;
      p1_oc_q       <= '0;
      p2_vld_q      <= 1'b0;
      p2_oc_q       <= '0;
      acc_vld_q     <= '0;
      out_valid_q   <= 1'b0;
      out_channel_q <= '0;
      out_value_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SRC_CH:   src_q     <= cfg_data_i[CNT_W-1:0];
          CFG_DST_CH:   dst_q     <= cfg_data_i[CNT_W-1:0];
          CFG_MODE:     mode_q    <= cfg_data_i[2:0];
          CFG_BIAS_EN:  bias_en_q <= cfg_data_i[0];
          CFG_SLOPE_LO: low_q     <= cfg_data_i;
          CFG_RANGE_HI: high_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end

      p1_vld_q <= issue;
      p1_oc_q  <= oc_idx;
      p2_vld_q <= p1_vld_q;
      p2_oc_q  <= p1_oc_q;
      if (p2_vld_q) begin
        acc_vld_q[p2_oc_q] <= 1'b1;
      end

      // In S_ACT the result step below decides the output register alone.
      if (out_valid_q && out_o.ready && (state_q != S_ACT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept && (in_i.action == ACT_SAMPLE)) begin
            ic_q    <= count_q[IN_IDX_W-1:0];
            ic_ok_q <= (count_q < CNT_W'(MAX_IN_CH));
            count_q <= count_q + 1'b1;
            oc_q    <= '0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            oc_q <= oc_q + 1'b1;
          end else if (pipe_empty) begin
            oc_q <= '0;
            if (count_q >= src_lim) begin
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RD:  state_q <= S_SUM;
        S_SUM: state_q <= S_MUL;
        S_MUL: state_q <= S_ACT;
        S_ACT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_channel_q <= oc_idx;
            out_value_q   <= act_val;
            out_last_q    <= last_oc;
            if (last_oc) begin
              acc_vld_q <= '0;
              count_q   <= '0;
              state_q   <= S_IDLE;
            end else begin
              oc_q    <= oc_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/pca_conv_checker.sv
// Checker for the pointwise convolution block: predicts every result beat and compares it.
`timescale 1ns / 1ps
module pca_conv_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pca_in_if                              in_mon,
  pca_out_if                             out_mon,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import pca_pkg::*;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]    ch;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } chan_result_t;

  logic signed [VAL_W-1:0] weight_q [W_DEPTH];
  logic signed [VAL_W-1:0] bias_q   [MAX_OUT_CH];
  logic signed [VAL_W-1:0] slope_q  [MAX_OUT_CH];
  logic signed [ACC_W-1:0] acc_q    [MAX_OUT_CH];
  logic [CNT_W-1:0]        chan_cnt;

  logic [6:0]              src_r;
  logic [6:0]              dst_r;
  logic [2:0]              mode_r;
  logic                    bias_en_r;
  logic signed [VAL_W-1:0] slope_lo_r;
  logic signed [VAL_W-1:0] range_hi_r;

  chan_result_t channel_results_q [$];
  int fails;
  int checked;

  // Adds half an LSB of the target scale, then floors.
  function automatic longint round_shr(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_q88(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[VAL_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : conv_model
    int dn;
    int sn;
    int ic;
    int oc;
    longint v;
    longint slope;
    longint lim_lo;
    longint lim_hi;
    logic signed [2*VAL_W-1:0] prod;
    logic signed [VAL_W-1:0] smp;
    chan_result_t want;
    if (!rst_ni) begin
      for (oc = 0; oc < MAX_OUT_CH; oc++) acc_q[oc] = '0;
      chan_cnt   = '0;
      src_r      = 7'd1;
      dst_r      = 7'd1;
      mode_r     = MODE_IDENT;
      bias_en_r  = 1'b1;
      slope_lo_r = 16'sh0000;
      range_hi_r = 16'sh7FFF;
      channel_results_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (channel_results_q.size() == 0) begin
          $error("unexpected result beat: out_channel %0d out_value %0d last %0b",
                 out_mon.out_channel, out_mon.out_value, out_mon.last);
          fails++;
        end else begin
          want = channel_results_q.pop_front();
          if (out_mon.out_channel !== want.ch) begin
            $error("out_channel: expected %0d, got %0d", want.ch, out_mon.out_channel);
            fails++;
          end
          if (out_mon.out_value !== want.val) begin
            $error("out_value: expected %0d, got %0d", want.val, out_mon.out_value);
            fails++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_mon.last);
            fails++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SRC_CH:   src_r      = cfg_data_i[6:0];
          CFG_DST_CH:   dst_r      = cfg_data_i[6:0];
          CFG_MODE:     mode_r     = cfg_data_i[2:0];
          CFG_BIAS_EN:  bias_en_r  = cfg_data_i[0];
          CFG_SLOPE_LO: slope_lo_r = cfg_data_i;
          CFG_RANGE_HI: range_hi_r = cfg_data_i;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        case (action_e'(in_mon.action))
          ACT_WEIGHT:
            weight_q[int'(in_mon.in_index) * MAX_OUT_CH + int'(in_mon.out_index)] = in_mon.value;
          ACT_BIAS:  bias_q[in_mon.out_index]  = in_mon.value;
          ACT_SLOPE: slope_q[in_mon.out_index] = in_mon.value;
          default: begin
            dn  = (dst_r == 0) ? 1 : (dst_r > MAX_OUT_CH) ? MAX_OUT_CH : int'(dst_r);
            sn  = (src_r == 0) ? 1 : (src_r > SRC_MAX) ? SRC_MAX : int'(src_r);
            smp = in_mon.value;
            ic  = int'(chan_cnt);
            if (ic < MAX_IN_CH) begin
              for (oc = 0; oc < dn; oc++) begin
                prod      = smp * weight_q[ic * MAX_OUT_CH + oc];
                acc_q[oc] = acc_q[oc] + prod;
              end
            end
            chan_cnt = chan_cnt + 1'b1;
            // The pixel closes on the sample that brings the count up to the limit.
            if (int'(chan_cnt) >= sn) begin
              for (oc = 0; oc < dn; oc++) begin
                v = longint'(acc_q[oc]);
                if (bias_en_r) v = v + longint'(bias_q[oc]) * 256;
                case (mode_r)
                  MODE_RELU: want.val = sat_q88(round_shr((v < 0) ? 0 : v, 8));
                  MODE_LEAKY, MODE_PRELU: begin
                    slope = (mode_r == MODE_LEAKY) ? longint'(slope_lo_r)
                                                   : longint'(slope_q[oc]);
                    want.val = (v >= 0) ? sat_q88(round_shr(v, 8))
                                        : sat_q88(round_shr(slope * v, 16));
                  end
                  MODE_CLAMP: begin
                    lim_lo = longint'(slope_lo_r) * 256;
                    lim_hi = longint'(range_hi_r) * 256;
                    // With an inverted range the upper limit is applied last and wins.
                    if (v < lim_lo) v = lim_lo;
                    if (v > lim_hi) v = lim_hi;
                    want.val = sat_q88(round_shr(v, 8));
                  end
                  default: want.val = sat_q88(round_shr(v, 8));
                endcase
                want.ch   = OUT_IDX_W'(oc);
                want.last = (oc == dn - 1);
                channel_results_q.push_back(want);
              end
              for (oc = 0; oc < MAX_OUT_CH; oc++) acc_q[oc] = '0;
              chan_cnt = '0;
            end
          end
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= channel_results_q.size();
    checked_o    <= checked;
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the pointwise convolution block.
`timescale 1ns / 1ps
module tb_top;
  import pca_pkg::*;

  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_BEATS  = 100;
  // An activation code with no defined meaning; it must act as identity.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int beats;
  int pixels;
  int cycle_cnt;
  bit hold_req;
  bit src_idle_on;
  bit snk_idle_on;

  // Which store entries have been loaded, so that no sample reads an empty one.
  bit w_done [W_DEPTH];
  bit b_done [MAX_OUT_CH];
  bit s_done [MAX_OUT_CH];
  int src_lim = 1;
  int dst_lim = 1;
  bit bias_on = 1'b1;
  bit prelu_on = 1'b0;
  int cc_trk = 0;

  always #2 clk_i = ~clk_i;

  pca_in_if  in_bus ();
  pca_out_if out_bus ();

  pointwise_conv_activation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  pca_conv_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Mostly values within +-2.0, with some full-range values and the extremes.
  function automatic logic [VAL_W-1:0] pick_q88();
    case ($urandom_range(0, 7))
      0, 1:    return VAL_W'($urandom);
      2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return VAL_W'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic send_beat(action_e act, logic [IN_IDX_W-1:0] ii,
                           logic [OUT_IDX_W-1:0] oi, logic [VAL_W-1:0] v);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.in_index  <= ii;
    in_bus.out_index <= oi;
    in_bus.value     <= v;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
    beats++;
  endtask

  task automatic send_load(action_e act, logic [IN_IDX_W-1:0] ii,
                           logic [OUT_IDX_W-1:0] oi, logic [VAL_W-1:0] v);
    send_beat(act, ii, oi, v);
    case (act)
      ACT_WEIGHT: w_done[int'(ii) * MAX_OUT_CH + int'(oi)] = 1'b1;
      ACT_BIAS:   b_done[oi] = 1'b1;
      ACT_SLOPE:  s_done[oi] = 1'b1;
      default: ;
    endcase
  endtask

  // Sends one sample, first loading whatever store entries it will read.
  task automatic push_sample(logic [VAL_W-1:0] v);
    int oc;
    for (oc = 0; oc < dst_lim; oc++)
      if (!w_done[cc_trk * MAX_OUT_CH + oc])
        send_load(ACT_WEIGHT, IN_IDX_W'(cc_trk), OUT_IDX_W'(oc), pick_q88());
    if (cc_trk + 1 >= src_lim) begin
      for (oc = 0; oc < dst_lim; oc++) begin
        if (bias_on && !b_done[oc])
          send_load(ACT_BIAS, IN_IDX_W'($urandom), OUT_IDX_W'(oc), pick_q88());
        if (prelu_on && !s_done[oc])
          send_load(ACT_SLOPE, IN_IDX_W'($urandom), OUT_IDX_W'(oc), pick_q88());
      end
    end
    send_beat(ACT_SAMPLE, IN_IDX_W'($urandom), OUT_IDX_W'($urandom), v);
    cc_trk = cc_trk + 1;
    if (cc_trk >= src_lim) begin
      cc_trk = 0;
      pixels++;
    end
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk_i);
  endtask

  task automatic apply_cfg(logic [6:0] src, logic [6:0] dst, logic [2:0] mode, logic ben,
                           logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    cfg_write(CFG_SRC_CH, CFG_DATA_W'(src));
    cfg_write(CFG_DST_CH, CFG_DATA_W'(dst));
    cfg_write(CFG_MODE, CFG_DATA_W'(mode));
    cfg_write(CFG_BIAS_EN, CFG_DATA_W'(ben));
    cfg_write(CFG_SLOPE_LO, lo);
    cfg_write(CFG_RANGE_HI, hi);
    cfg_we   <= 1'b0;
    src_lim  = (src == 0) ? 1 : (src > SRC_MAX) ? SRC_MAX : int'(src);
    dst_lim  = (dst == 0) ? 1 : (dst > MAX_OUT_CH) ? MAX_OUT_CH : int'(dst);
    bias_on  = ben;
    prelu_on = (mode == MODE_PRELU);
  endtask

  // Waits until every predicted result has left and a sample still in work has finished.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int gap;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = snk_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int n;
    int phase;
    int rnd_beats;
    logic [6:0] src;
    logic [6:0] dst;
    in_bus.valid     = 1'b0;
    in_bus.action    = ACT_WEIGHT;
    in_bus.in_index  = '0;
    in_bus.out_index = '0;
    in_bus.value     = '0;
    src_idle_on      = 1'b1;
    snk_idle_on      = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: one channel each way, identity, bias on. Drive both rails.
    send_load(ACT_WEIGHT, '0, '0, 16'h8000);
    send_load(ACT_BIAS, '0, '0, 16'h7FFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h0001);
    drain();

    apply_cfg(7'd3, 7'd2, MODE_RELU, 1'b0, 16'h0000, 16'h7FFF);
    repeat (4) push_sample(pick_q88());
    // One sample of the next pixel is in; widen the output side before the rest arrives.
    drain();
    apply_cfg(7'd3, 7'd4, MODE_LEAKY, 1'b1, 16'h0040, 16'h7FFF);
    repeat (2) push_sample(pick_q88());
    drain();

    apply_cfg(7'd2, 7'd3, MODE_CLAMP, 1'b1, 16'h0100, 16'hFF00);
    repeat (2) push_sample(pick_q88());
    drain();
    apply_cfg(7'd2, 7'd3, MODE_CLAMP, 1'b1, 16'hFE00, 16'h0180);
    repeat (2) push_sample(pick_q88());
    drain();

    // Out-of-range counts clamp to one input and all 64 outputs. The receiver then
    // stops for a long stretch while further pixels keep coming.
    apply_cfg(7'd0, 7'd100, MODE_PRELU, 1'b1, 16'h0000, 16'h7FFF);
    push_sample(pick_q88());
    hold_req = 1'b1;
    repeat (3) push_sample(pick_q88());

    phase     = 0;
    rnd_beats = 0;
    while (rnd_beats < RANDOM_BEATS) begin
      drain();
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 0)
        apply_cfg(7'd64, 7'd1, MODE_UNUSED, 1'b1, pick_q88(), pick_q88());
      else if (phase == 1)
        apply_cfg(7'd1, 7'd64, 3'($urandom_range(0, 7)), 1'($urandom), pick_q88(), pick_q88());
      else begin
        src = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 6));
        dst = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
        apply_cfg(src, dst, 3'($urandom_range(0, 7)), 1'($urandom), pick_q88(), pick_q88());
      end
      n = $urandom_range(10, 40);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          send_load(action_e'($urandom_range(0, 2)), IN_IDX_W'($urandom),
                    OUT_IDX_W'($urandom), pick_q88());
        else
          push_sample(pick_q88());
        rnd_beats++;
      end
      // Close the open pixel so that the next settings start on a clean count.
      while (cc_trk != 0) begin
        push_sample(pick_q88());
        rnd_beats++;
      end
      phase++;
    end
    drain();

    $display("Run: %0d input beats, %0d pixels, %0d result beats checked.",
             beats, pixels, checked);
    $display("Covered the five activation modes, an undefined code, 1 to 64 channels and a long stall.");
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### pointwise_conv_activation.f
rtl/core/pca_pkg.sv
rtl/core/pca_if.sv
rtl/core/pointwise_conv_activation.sv
tb/sv/pca_conv_checker.sv
tb/sv/tb_top.sv
